[hw/rtl/jdm_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Joystick drive mixer package
// Shared types, codes and constants for the drive mixer front end, command
// queue and execution back end.
// ---------------------------------------------------------------------------
package jdm_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_LEFT_TRIM        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RIGHT_TRIM       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STICK_DEADZONE   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_DEADZONE   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DEFAULT_SPEED    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_RAMP_STEP        = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_RAMP_INTERVAL_MS = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_KICK_SPEED       = 3'd7;

  // Depth of the queue between the classifier and the executor.
  localparam int unsigned QueueDepth = 2;

  // Arithmetic constants.
  localparam logic [7:0] ArcQ8     = 8'd179;  // arc slow-down factor, Q0.8
  localparam logic [6:0] MapSlope  = 7'd105;  // speed stick slope numerator
  localparam logic [8:0] MapBase   = 9'd150;  // lowest mapped speed
  localparam logic [7:0] KickFloor = 8'd100;  // kept speed below this kicks

  // Drive mode codes as they appear on the result.
  typedef enum logic [2:0] {
    MODE_STOP       = 3'd0,
    MODE_FORWARD    = 3'd1,
    MODE_BACKWARD   = 3'd2,
    MODE_CRAB_LEFT  = 3'd3,
    MODE_CRAB_RIGHT = 3'd4,
    MODE_ROT_CCW    = 3'd5,
    MODE_ROT_CW     = 3'd6
  } mode_e;

  // How the back end has to carry out a command.
  typedef enum logic [1:0] {
    KIND_STOP   = 2'd0,
    KIND_ROTATE = 2'd1,
    KIND_ARC    = 2'd2,
    KIND_RAMP   = 2'd3
  } kind_e;

  // Configuration register file contents.
  typedef struct packed {
    logic [8:0]  left_trim;
    logic [8:0]  right_trim;
    logic [6:0]  stick_deadzone;
    logic [7:0]  speed_deadzone;
    logic [7:0]  default_speed;
    logic [7:0]  ramp_step;
    logic [15:0] ramp_interval_ms;
    logic [7:0]  kick_speed;
  } cfg_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    kind_e       kind;
    mode_e       mode;
    logic        slow_left;
    logic [7:0]  target;
    logic [31:0] now_ms;
  } cmd_t;

endpackage

[hw/rtl/joystick_drive_mixer_with_ramp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Joystick drive mixer with speed ramp
// Turns controller samples into a drive mode and trimmed left and right
// motor duty values, slew-limiting the speed of straight and crab moves.
// ---------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_t* stream and results leave on the m_t* stream;
//   a transfer happens when tvalid and tready are both high. Each sample
//   gives exactly one result, in order.
//   Configuration registers are written through cfg_valid_i / cfg_index_i /
//   cfg_data_i; cfg_ready_o is always high. Write them only while no sample
//   is in flight.
//   Timing: a sample is classified in the cycle of its transfer and queued.
//   The executor takes one sample at a time through its steps (pop with ramp
//   kick and interval check, ramp step, left trim multiply, right trim
//   multiply into the output register) and pops the next sample only once
//   the result is loaded; left and right share the single trim multiplier.
//   If the receiver stalls, the result waits in the output register, the
//   executor holds its finished sample, and the 2-entry queue keeps taking
//   samples until it fills; then s_tready_o drops.
//   Reset restores the register defaults, clears the kept ramp speed and
//   ramp timestamp and empties the queue.
// ---------------------------------------------------------------------------
module joystick_drive_mixer_with_ramp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Sample stream.
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  // stick_x[7:0], stick_y[15:8], speed_stick[23:16], turn_left_held[24],
  // turn_right_held[25], now_ms[57:26], zero [63:58]
  input  logic [63:0]                  s_tdata_i,
  // Result stream.
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  // drive_mode[2:0], left_pwm[10:3], right_pwm[18:11], speed_setting[26:19],
  // zero [31:27]
  output logic [31:0]                  m_tdata_o,
  // Configuration write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [jdm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [jdm_pkg::CfgDataW-1:0] cfg_data_i
);

  jdm_pkg::cfg_t cfg_q;
  jdm_pkg::cmd_t front_cmd, head_cmd;
  logic          push, pop, queue_full, queue_valid;
  logic [2:0]    drive_mode;
  logic [7:0]    left_pwm, right_pwm, speed_setting;

  // Configuration register file.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_trim        <= 9'd169;
      cfg_q.right_trim       <= 9'd256;
      cfg_q.stick_deadzone   <= 7'd20;
      cfg_q.speed_deadzone   <= 8'd30;
      cfg_q.default_speed    <= 8'd200;
      cfg_q.ramp_step        <= 8'd15;
      cfg_q.ramp_interval_ms <= 16'd30;
      cfg_q.kick_speed       <= 8'd180;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        jdm_pkg::CFG_LEFT_TRIM:        cfg_q.left_trim        <= cfg_data_i[8:0];
        jdm_pkg::CFG_RIGHT_TRIM:       cfg_q.right_trim       <= cfg_data_i[8:0];
        jdm_pkg::CFG_STICK_DEADZONE:   cfg_q.stick_deadzone   <= cfg_data_i[6:0];
        jdm_pkg::CFG_SPEED_DEADZONE:   cfg_q.speed_deadzone   <= cfg_data_i[7:0];
        jdm_pkg::CFG_DEFAULT_SPEED:    cfg_q.default_speed    <= cfg_data_i[7:0];
        jdm_pkg::CFG_RAMP_STEP:        cfg_q.ramp_step        <= cfg_data_i[7:0];
        jdm_pkg::CFG_RAMP_INTERVAL_MS: cfg_q.ramp_interval_ms <= cfg_data_i;
        jdm_pkg::CFG_KICK_SPEED:       cfg_q.kick_speed       <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Classifier.
  jdm_front u_front (
    .s_tvalid_i        (s_tvalid_i),
    .s_tready_o        (s_tready_o),
    .stick_x_i         (s_tdata_i[7:0]),
    .stick_y_i         (s_tdata_i[15:8]),
    .speed_stick_i     (s_tdata_i[23:16]),
    .turn_left_held_i  (s_tdata_i[24]),
    .turn_right_held_i (s_tdata_i[25]),
    .now_ms_i          (s_tdata_i[57:26]),
    .cfg_i             (cfg_q),
    .queue_full_i      (queue_full),
    .push_o            (push),
    .cmd_o             (front_cmd)
  );

  // Command queue.
  jdm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .cmd_o   (head_cmd)
  );

  // Executor.
  jdm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .valid_i         (queue_valid),
    .cmd_i           (head_cmd),
    .pop_o           (pop),
    .m_tvalid_o      (m_tvalid_o),
    .m_tready_i      (m_tready_i),
    .drive_mode_o    (drive_mode),
    .left_pwm_o      (left_pwm),
    .right_pwm_o     (right_pwm),
    .speed_setting_o (speed_setting)
  );

  assign m_tdata_o = {5'd0, speed_setting, right_pwm, left_pwm, drive_mode};

endmodule

[hw/rtl/jdm_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Drive mixer front end
// Accepts controller samples, maps the speed stick to a target speed and
// classifies the sample into a stop, rotate, arc or ramped move command.
// ---------------------------------------------------------------------------
module jdm_front (
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic signed [7:0]  stick_x_i,
  input  logic signed [7:0]  stick_y_i,
  input  logic signed [7:0]  speed_stick_i,
  input  logic               turn_left_held_i,
  input  logic               turn_right_held_i,
  input  logic [31:0]        now_ms_i,
  input  jdm_pkg::cfg_t      cfg_i,
  input  logic               queue_full_i,
  output logic               push_o,
  output jdm_pkg::cmd_t      cmd_o
);

  logic [7:0]  mag_x, mag_y, mag_s;
  logic [8:0]  map_num;
  logic [14:0] map_prod;
  logic [15:0] map_div;
  logic [8:0]  map_sum;
  logic [7:0]  target;
  logic        x_big, y_big, any_btn;

  // The queue accepts while it has room.
  assign s_tready_o = !queue_full_i;
  assign push_o     = s_tvalid_i && !queue_full_i;

  // Stick magnitudes; the most negative value maps to 128.
  assign mag_x = stick_x_i[7]     ? (~stick_x_i + 8'd1)     : stick_x_i;
  assign mag_y = stick_y_i[7]     ? (~stick_y_i + 8'd1)     : stick_y_i;
  assign mag_s = speed_stick_i[7] ? (~speed_stick_i + 8'd1) : speed_stick_i;

  // Speed map: (128 - s) * 105 / 255 + 150, division by 255 done as a
  // reciprocal with rounding correction, exact for the range used here.
  assign map_num  = 9'd128 - {speed_stick_i[7], speed_stick_i};
  assign map_prod = 15'(map_num) * 15'(jdm_pkg::MapSlope);
  assign map_div  = 16'(map_prod) + 16'd1 + 16'(map_prod >> 8);
  assign map_sum  = {1'b0, map_div[15:8]} + jdm_pkg::MapBase;

  always_comb begin
    if (mag_s < cfg_i.speed_deadzone) begin
      target = cfg_i.default_speed;
    end else if (map_sum[8]) begin
      target = 8'hFF;
    end else begin
      target = map_sum[7:0];
    end
  end

  assign x_big   = mag_x > {1'b0, cfg_i.stick_deadzone};
  assign y_big   = mag_y > {1'b0, cfg_i.stick_deadzone};
  assign any_btn = turn_left_held_i || turn_right_held_i;

  // Classification of the sample into a command.
  always_comb begin
    cmd_o.target    = target;
    cmd_o.now_ms    = now_ms_i;
    cmd_o.slow_left = turn_left_held_i;
    if (y_big && any_btn) begin
      cmd_o.kind = jdm_pkg::KIND_ARC;
      cmd_o.mode = stick_y_i[7] ? jdm_pkg::MODE_FORWARD : jdm_pkg::MODE_BACKWARD;
    end else if (any_btn) begin
      cmd_o.kind = jdm_pkg::KIND_ROTATE;
      cmd_o.mode = turn_left_held_i ? jdm_pkg::MODE_ROT_CCW : jdm_pkg::MODE_ROT_CW;
    end else if (y_big || x_big) begin
      cmd_o.kind = jdm_pkg::KIND_RAMP;
      if (mag_y > mag_x) begin
        cmd_o.mode = stick_y_i[7] ? jdm_pkg::MODE_FORWARD : jdm_pkg::MODE_BACKWARD;
      end else begin
        cmd_o.mode = stick_x_i[7] ? jdm_pkg::MODE_CRAB_LEFT : jdm_pkg::MODE_CRAB_RIGHT;
      end
    end else begin
      cmd_o.kind = jdm_pkg::KIND_STOP;
      cmd_o.mode = jdm_pkg::MODE_STOP;
    end
  end

endmodule

[hw/rtl/jdm_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Drive mixer command queue
// Short first-in first-out queue of classified commands between the front
// end and the back end.
// ---------------------------------------------------------------------------
module jdm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jdm_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output jdm_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = (jdm_pkg::QueueDepth > 1) ? $clog2(jdm_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(jdm_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(jdm_pkg::QueueDepth);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(jdm_pkg::QueueDepth - 1);

  jdm_pkg::cmd_t   entry_q [jdm_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == DepthCnt);
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

[hw/rtl/jdm_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Drive mixer back end
// Executes queued commands: updates the ramped speed, applies arc scaling,
// applies per-side trims to arc and ramp moves through one shared multiplier and holds the result.
// ---------------------------------------------------------------------------
module jdm_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  jdm_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  input  jdm_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output logic [2:0]    drive_mode_o,
  output logic [7:0]    left_pwm_o,
  output logic [7:0]    right_pwm_o,
  output logic [7:0]    speed_setting_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_LEFT,
    ST_RIGHT
  } state_e;

  state_e        state_q;
  jdm_pkg::cmd_t cmd_q;
  logic [15:0]   arc_pre_q;
  logic          due_q;
  logic [7:0]    ramp_q;
  logic [31:0]   last_q;
  logic [7:0]    left_q;
  logic          m_tvalid_q;
  logic [2:0]    drive_mode_q;
  logic [7:0]    left_pwm_q, right_pwm_q, speed_setting_q;

  logic [31:0] elapsed;
  logic [7:0]  kicked;
  logic [8:0]  ramp_up;
  logic [7:0]  ramp_diff;
  logic [7:0]  ramp_d;
  logic        slow_side;
  logic [7:0]  base;
  logic [15:0] mul_a;
  logic [8:0]  mul_b;
  logic [24:0] mul_p;
  logic [7:0]  side_pwm;
  logic        out_free;

  assign pop_o    = (state_q == ST_IDLE) && valid_i;
  assign out_free = !m_tvalid_q || m_tready_i;

  // Kick and interval check for the command at the queue head.
  assign elapsed = cmd_i.now_ms - last_q;
  assign kicked  = (ramp_q < jdm_pkg::KickFloor) ? cfg_i.kick_speed : ramp_q;

  // One ramp step toward the target without overshooting it.
  assign ramp_up   = {1'b0, ramp_q} + {1'b0, cfg_i.ramp_step};
  assign ramp_diff = ramp_q - cmd_q.target;
  always_comb begin
    if (ramp_q < cmd_q.target) begin
      ramp_d = (ramp_up > {1'b0, cmd_q.target}) ? cmd_q.target : ramp_up[7:0];
    end else if (ramp_q > cmd_q.target) begin
      ramp_d = (ramp_diff < cfg_i.ramp_step) ? cmd_q.target : ramp_q - cfg_i.ramp_step;
    end else begin
      ramp_d = ramp_q;
    end
  end

  // Shared trim multiplier; the duty operand is unsigned Q8.8 and the trim is unsigned Q1.8.
  assign slow_side = (cmd_q.kind == jdm_pkg::KIND_ARC) &&
                     ((state_q == ST_LEFT) ? cmd_q.slow_left : !cmd_q.slow_left);
  assign base  = (cmd_q.kind == jdm_pkg::KIND_ARC) ? cmd_q.target : ramp_q;
  assign mul_a = slow_side ? arc_pre_q : {base, 8'd0};
  assign mul_b = (state_q == ST_LEFT) ? cfg_i.left_trim : cfg_i.right_trim;
  assign mul_p = 25'(mul_a) * 25'(mul_b);

  always_comb begin
    case (cmd_q.kind)
      jdm_pkg::KIND_STOP:   side_pwm = 8'd0;
      jdm_pkg::KIND_ROTATE: side_pwm = cmd_q.target;
      default:              side_pwm = mul_p[24] ? 8'hFF : mul_p[23:16];
    endcase
  end

  // Sequencer with kept ramp state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      cmd_q           <= '0;
      arc_pre_q       <= '0;
      due_q           <= 1'b0;
      ramp_q          <= '0;
      last_q          <= '0;
      left_q          <= '0;
      m_tvalid_q      <= 1'b0;
      drive_mode_q    <= '0;
      left_pwm_q      <= '0;
      right_pwm_q     <= '0;
      speed_setting_q <= '0;
    end else begin
      // The output is loaded when a command finishes, else freed on its transfer.
      if (state_q == ST_RIGHT && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tvalid_q && m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (valid_i) begin
            cmd_q     <= cmd_i;
            arc_pre_q <= 16'(cmd_i.target) * 16'(jdm_pkg::ArcQ8);
            due_q     <= elapsed >= {16'd0, cfg_i.ramp_interval_ms};
            if (cmd_i.kind == jdm_pkg::KIND_RAMP) begin
              ramp_q <= kicked;
            end else if (cmd_i.kind == jdm_pkg::KIND_STOP) begin
              ramp_q <= '0;
            end
            state_q <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (cmd_q.kind == jdm_pkg::KIND_RAMP && due_q) begin
            last_q <= cmd_q.now_ms;
            ramp_q <= ramp_d;
          end
          state_q <= ST_LEFT;
        end
        ST_LEFT: begin
          left_q  <= side_pwm;
          state_q <= ST_RIGHT;
        end
        ST_RIGHT: begin
          if (out_free) begin
            drive_mode_q    <= cmd_q.mode;
            left_pwm_q      <= left_q;
            right_pwm_q     <= side_pwm;
            speed_setting_q <= cmd_q.target;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid_o      = m_tvalid_q;
  assign drive_mode_o    = drive_mode_q;
  assign left_pwm_o      = left_pwm_q;
  assign right_pwm_o     = right_pwm_q;
  assign speed_setting_o = speed_setting_q;

  // A popped command always goes through the ramp step next.
  a_pop_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == ST_STEP)
    else $error("popped command did not enter the ramp step");

  // Kept ramp state only moves on pop and step; this checks that it holds across the left trim multiply.
  a_ramp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LEFT |=> $stable(ramp_q) && $stable(last_q))
    else $error("ramp state changed during trim multiply");

  // A stop result carries zero duty on both sides.
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && drive_mode_q == jdm_pkg::MODE_STOP) |->
      (left_pwm_q == 8'd0 && right_pwm_q == 8'd0))
    else $error("stop result with nonzero duty");

  // A finished command is loaded into the output register with its mode.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RIGHT && out_free) |=>
      (m_tvalid_q && drive_mode_q == $past(cmd_q.mode)))
    else $error("finished command not presented on the output");

endmodule
